/* rtl/scml_pkg.sv */
// Shared constants and types for the serial command line matcher.
package scml_pkg;

    localparam int BUF_DEPTH   = 32;
    localparam int POS_W       = $clog2(BUF_DEPTH);
    localparam int NUM_ENTRIES = 6;
    localparam int IDX_W       = 3;
    localparam int CODE_W      = 8;
    localparam int LEN_W       = 6;
    localparam int ENTRY_W     = CODE_W + LEN_W;
    localparam int BYTE_W      = 8;

    localparam logic [BYTE_W-1:0] CH_NEWLINE = 8'd10;
    localparam logic [BYTE_W-1:0] CH_RETURN  = 8'd13;

    typedef logic [ENTRY_W-1:0] entry_t;

    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_READ = 4'b0010,
        S_LOAD = 4'b0100,
        S_UNK  = 4'b1000
    } state_t;

endpackage

/* rtl/serial_command_line_matcher_unit.sv */
// Serial command line matcher: line store, table match and result streaming.
//
// Input channel (in_valid/in_ready, rx_byte) takes one received byte per
// transaction. Carriage return is dropped, other bytes go into the line
// store, newline closes the line. Bytes are taken only while idle.
// On a newline that closes a nonempty line without overflow, the command
// table is checked in the same cycle. A match streams the line bytes from
// the line store, one result per byte, each through a store read state
// (S_READ) and then an output load state (S_LOAD), where a stall waits.
// No match gives one unknown result, loaded once the output is free.
// Input is not taken while a line is being read out of the store.
// Results sit in an output register (out_valid/out_ready); a stall holds
// the result and pauses the read-out. The next input byte is taken while
// the final result of a line still waits.
// Configuration (cfg_valid/cfg_ready, cfg_index, cfg_data) writes one table
// entry per transaction, none past the table; cfg_ready is always high.
// Reset clears the table, the write position, the overflow flag and the
// output valid flag; the line store keeps no reset value.
module serial_command_line_matcher_unit
    import scml_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  logic [BYTE_W-1:0]   rx_byte,
    output logic                out_valid,
    input  logic                out_ready,
    output logic [BYTE_W-1:0]   line_byte,
    output logic [IDX_W-1:0]    command_index,
    output logic                unknown,
    output logic                last,
    input  logic                cfg_valid,
    output logic                cfg_ready,
    input  logic [IDX_W-1:0]    cfg_index,
    input  logic [ENTRY_W-1:0]  cfg_data
);

    logic [BYTE_W-1:0] line_mem [BUF_DEPTH];
    logic [BYTE_W-1:0] rd_data_reg;

    entry_t            entry_reg [NUM_ENTRIES];
    state_t            state_reg, state_next;
    logic [POS_W-1:0]  wp_reg, wp_next;
    logic              ovf_reg, ovf_next;
    logic [POS_W-1:0]  len_reg, len_next;
    logic [POS_W-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [IDX_W-1:0]  idx_reg, idx_next;
    logic [BYTE_W-1:0] first_reg;

    logic              out_valid_reg, out_valid_next;
    logic [BYTE_W-1:0] out_byte_reg, out_byte_next;
    logic [IDX_W-1:0]  out_idx_reg, out_idx_next;
    logic              out_unk_reg, out_unk_next;
    logic              out_last_reg, out_last_next;

    logic              in_acc;
    logic              store_wr;
    logic              out_free;
    logic              found;
    logic [IDX_W-1:0]  found_idx;
    logic              scan_stop;

    assign in_ready      = (state_reg == S_IDLE);
    assign in_acc        = in_valid && in_ready;
    assign store_wr      = in_acc && (rx_byte != CH_RETURN) && (rx_byte != CH_NEWLINE);
    assign out_free      = !out_valid_reg || out_ready;
    assign cfg_ready     = 1'b1;

    assign out_valid     = out_valid_reg;
    assign line_byte     = out_byte_reg;
    assign command_index = out_idx_reg;
    assign unknown       = out_unk_reg;
    assign last          = out_last_reg;

    always_comb
    begin
        found     = 1'b0;
        found_idx = '0;
        scan_stop = 1'b0;
        for (int i = 0; i < NUM_ENTRIES; i++)
        begin
            if (!scan_stop)
            begin
                if (entry_reg[i][CODE_W-1:0] == '0)
                begin
                    scan_stop = 1'b1;
                end
                else if ((entry_reg[i][CODE_W-1:0] == first_reg) &&
                         (entry_reg[i][ENTRY_W-1:CODE_W] == LEN_W'(wp_reg)))
                begin
                    found     = 1'b1;
                    found_idx = IDX_W'(i);
                    scan_stop = 1'b1;
                end
            end
        end
    end

    always_comb
    begin
        state_next     = state_reg;
        wp_next        = wp_reg;
        ovf_next       = ovf_reg;
        len_next       = len_reg;
        rd_ptr_next    = rd_ptr_reg;
        idx_next       = idx_reg;
        out_valid_next = out_valid_reg;
        out_byte_next  = out_byte_reg;
        out_idx_next   = out_idx_reg;
        out_unk_next   = out_unk_reg;
        out_last_next  = out_last_reg;

        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            S_IDLE:
            begin
                if (store_wr)
                begin
                    if (wp_reg == POS_W'(BUF_DEPTH - 1))
                    begin
                        wp_next  = '0;
                        ovf_next = 1'b1;
                    end
                    else
                    begin
                        wp_next = wp_reg + 1'b1;
                    end
                end
                else if (in_acc && (rx_byte == CH_NEWLINE))
                begin
                    if (ovf_reg)
                    begin
                        ovf_next = 1'b0;
                        wp_next  = '0;
                    end
                    else if (wp_reg != '0)
                    begin
                        wp_next     = '0;
                        len_next    = wp_reg;
                        rd_ptr_next = '0;
                        idx_next    = found_idx;
                        state_next  = found ? S_READ : S_UNK;
                    end
                end
            end
            S_READ:
            begin
                state_next = S_LOAD;
            end
            S_LOAD:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    out_byte_next  = rd_data_reg;
                    out_idx_next   = idx_reg;
                    out_unk_next   = 1'b0;
                    out_last_next  = (rd_ptr_reg == len_reg - 1'b1);
                    rd_ptr_next    = rd_ptr_reg + 1'b1;
                    state_next     = (rd_ptr_reg == len_reg - 1'b1) ? S_IDLE : S_READ;
                end
            end
            S_UNK:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    out_byte_next  = '0;
                    out_idx_next   = '0;
                    out_unk_next   = 1'b1;
                    out_last_next  = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // line store: writes only in idle, reads only during read-out
    always_ff @(posedge clk)
    begin
        if (store_wr)
        begin
            line_mem[wp_reg] <= rx_byte;
        end
        if (state_reg == S_READ)
        begin
            rd_data_reg <= line_mem[rd_ptr_reg];
        end
    end

    always_ff @(posedge clk)
    begin
        if (store_wr && (wp_reg == '0))
        begin
            first_reg <= rx_byte;
        end
        len_reg       <= len_next;
        rd_ptr_reg    <= rd_ptr_next;
        idx_reg       <= idx_next;
        out_byte_reg  <= out_byte_next;
        out_idx_reg   <= out_idx_next;
        out_unk_reg   <= out_unk_next;
        out_last_reg  <= out_last_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            wp_reg        <= '0;
            ovf_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
            for (int i = 0; i < NUM_ENTRIES; i++)
            begin
                entry_reg[i] <= '0;
            end
        end
        else
        begin
            state_reg     <= state_next;
            wp_reg        <= wp_next;
            ovf_reg       <= ovf_next;
            out_valid_reg <= out_valid_next;
            if (cfg_valid && cfg_ready && (cfg_index < IDX_W'(NUM_ENTRIES)))
            begin
                entry_reg[cfg_index] <= cfg_data;
            end
        end
    end

endmodule

/* rtl/scml_checker.sv */
// Port-level assertions for the serial command line matcher, bound to the top level.
module scml_checker
    import scml_pkg::*;
(
    input logic                clk,
    input logic                rst_n,
    input logic                in_ready,
    input logic                out_valid,
    input logic                out_ready,
    input logic [BYTE_W-1:0]   line_byte,
    input logic [IDX_W-1:0]    command_index,
    input logic                unknown,
    input logic                last
);

    // stalled transaction holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(line_byte) &&
        $stable(command_index) && $stable(unknown) && $stable(last))
        else $error("output changed while stalled");

    a_unk_form: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && unknown |-> last && (line_byte == '0) && (command_index == '0))
        else $error("malformed unknown result");

    a_idx_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> command_index < IDX_W'(NUM_ENTRIES))
        else $error("command index out of range");

    // input held off while a matched line is still streaming
    a_busy: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !unknown && !last |-> !in_ready)
        else $error("input taken during line read-out");

endmodule

bind serial_command_line_matcher_unit scml_checker u_scml_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_ready      (in_ready),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .line_byte     (line_byte),
    .command_index (command_index),
    .unknown       (unknown),
    .last          (last)
);

/* sim/tb_serial_command_line_matcher_unit.sv */
// Self-checking testbench for serial_command_line_matcher_unit with a line and table predictor.
module tb_serial_command_line_matcher_unit;
    import scml_pkg::*;

    localparam int SETTLE_CYCLES = 8;
    localparam int ITEMS_PER_PHASE = 60;
    localparam int NUM_PHASES = 6;
    localparam int TIMEOUT = 400000;
    localparam logic [CODE_W-1:0] TABLE_END = '0;

    typedef struct packed {
        logic [BYTE_W-1:0] line_byte;
        logic [IDX_W-1:0]  command_index;
        logic              unknown;
        logic              last;
    } scml_result_t;

    logic               clk = 1'b0;
    logic               rst_n = 1'b0;
    logic               in_valid = 1'b0;
    logic               in_ready;
    logic [BYTE_W-1:0]  rx_byte = '0;
    logic               out_valid;
    logic               out_ready = 1'b0;
    logic [BYTE_W-1:0]  line_byte;
    logic [IDX_W-1:0]   command_index;
    logic               unknown;
    logic               last;
    logic               cfg_valid = 1'b0;
    logic               cfg_ready;
    logic [IDX_W-1:0]   cfg_index = '0;
    logic [ENTRY_W-1:0] cfg_data = '0;

    // line and table model
    entry_t            cmd_table[NUM_ENTRIES] = '{default: '0};
    logic [BYTE_W-1:0] line_buf[BUF_DEPTH];
    int                fill_pos = 0;
    bit                overflowed = 1'b0;

    logic [BYTE_W-1:0] pending_bytes[$];
    scml_result_t      expected_results[$];
    entry_t            staged_table[NUM_ENTRIES];

    bit in_taken = 1'b0;
    int send_idle_pct = 33;
    int recv_idle_pct = 48;
    int queued_items = 0;
    int errors = 0;
    int bytes_taken = 0;
    int results_seen = 0;
    int matched_lines = 0;
    int unknown_lines = 0;
    int tables_loaded = 0;
    int spare_writes = 0;

    serial_command_line_matcher_unit dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .rx_byte       (rx_byte),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .line_byte     (line_byte),
        .command_index (command_index),
        .unknown       (unknown),
        .last          (last),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    function automatic void predict_byte(input logic [BYTE_W-1:0] b);
        int           hit;
        int           len;
        scml_result_t r;
        if (b == CH_RETURN)
            return;
        if (b != CH_NEWLINE)
        begin
            line_buf[fill_pos] = b;
            if (fill_pos == BUF_DEPTH - 1)
            begin
                fill_pos = 0;
                overflowed = 1'b1;
            end
            else
                fill_pos++;
            return;
        end
        if (overflowed)
        begin
            overflowed = 1'b0;
            fill_pos = 0;
            return;
        end
        len = fill_pos;
        if (len == 0)
            return;
        fill_pos = 0;
        hit = -1;
        for (int i = 0; i < NUM_ENTRIES; i++)
        begin
            if (cmd_table[i][CODE_W-1:0] == TABLE_END)
                break;
            if (cmd_table[i][CODE_W-1:0] == line_buf[0] &&
                int'(cmd_table[i][ENTRY_W-1:CODE_W]) == len)
            begin
                hit = i;
                break;
            end
        end
        if (hit < 0)
        begin
            r = '{line_byte: '0, command_index: '0, unknown: 1'b1, last: 1'b1};
            expected_results.push_back(r);
            return;
        end
        for (int k = 0; k < len; k++)
        begin
            r.line_byte = line_buf[k];
            r.command_index = IDX_W'(hit);
            r.unknown = 1'b0;
            r.last = (k == len - 1);
            expected_results.push_back(r);
        end
    endfunction

    function automatic void check_field(input string name, input int want, input int got);
        if (want != got)
        begin
            $error("%s: expected %0h, got %0h", name, want, got);
            errors++;
        end
    endfunction

    // input driver and receiver stalls
    always @(negedge clk)
    begin
        if (rst_n && (!in_valid || in_taken))
        begin
            if (pending_bytes.size() != 0 && $urandom_range(99) >= send_idle_pct)
            begin
                rx_byte <= pending_bytes.pop_front();
                in_valid <= 1'b1;
            end
            else
                in_valid <= 1'b0;
        end
        out_ready <= ($urandom_range(99) >= recv_idle_pct);
    end

    always @(posedge clk)
    begin : result_check
        scml_result_t want;
        if (rst_n)
        begin
            if (out_valid && out_ready)
            begin
                results_seen++;
                if (expected_results.size() == 0)
                begin
                    $error("unexpected result: byte %0h index %0d unknown %0b last %0b",
                           line_byte, command_index, unknown, last);
                    errors++;
                end
                else
                begin
                    want = expected_results.pop_front();
                    check_field("line_byte", want.line_byte, line_byte);
                    check_field("command_index", want.command_index, command_index);
                    check_field("unknown", want.unknown, unknown);
                    check_field("last", want.last, last);
                    if (want.last)
                    begin
                        if (want.unknown)
                            unknown_lines++;
                        else
                            matched_lines++;
                    end
                end
            end
            if (in_valid && in_ready)
            begin
                bytes_taken++;
                predict_byte(rx_byte);
            end
        end
        in_taken <= rst_n && in_valid && in_ready;
    end

    task automatic write_entry(input int idx, input entry_t val);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= IDX_W'(idx);
        cfg_data <= val;
        do
            @(posedge clk);
        while (!(cfg_valid && cfg_ready));
        if (idx < NUM_ENTRIES)
            cmd_table[idx] = val;
        else
            spare_writes++;
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    task automatic load_table(input bit spare_too, input entry_t spare_val);
        for (int i = 0; i < NUM_ENTRIES; i++)
            write_entry(i, staged_table[i]);
        if (spare_too)
            for (int i = NUM_ENTRIES; i < (1 << IDX_W); i++)
                write_entry(i, spare_val);
        tables_loaded++;
    endtask

    task automatic wait_drained();
        while (pending_bytes.size() != 0 || in_valid || expected_results.size() != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    function automatic logic [BYTE_W-1:0] body_byte();
        logic [BYTE_W-1:0] b;
        do
            b = BYTE_W'($urandom_range(255));
        while (b == CH_NEWLINE || b == CH_RETURN);
        return b;
    endfunction

    function automatic void push_byte(input logic [BYTE_W-1:0] b);
        pending_bytes.push_back(b);
        if (b != CH_RETURN)
            queued_items++;
    endfunction

    function automatic void push_line(input logic [BYTE_W-1:0] first, input int len);
        push_byte(first);
        for (int k = 1; k < len; k++)
        begin
            if ($urandom_range(9) == 0)
                push_byte(CH_RETURN);
            push_byte(body_byte());
        end
        push_byte(CH_NEWLINE);
    endfunction

    function automatic entry_t make_entry(input entry_t prev);
        logic [CODE_W-1:0] code;
        logic [LEN_W-1:0]  need;
        int                r;
        r = $urandom_range(99);
        if (r < 8)
            code = TABLE_END;
        else if (r < 28)
            code = prev[CODE_W-1:0];
        else if (r < 34)
            code = '1;
        else
            code = CODE_W'($urandom_range(1, 255));
        r = $urandom_range(99);
        if (r < 65)
            need = LEN_W'($urandom_range(1, 6));
        else if (r < 85)
            need = LEN_W'($urandom_range(7, BUF_DEPTH - 1));
        else if (r < 95)
            case ($urandom_range(3))
                0: need = '0;
                1: need = LEN_W'(BUF_DEPTH - 1);
                2: need = LEN_W'(BUF_DEPTH);
                default: need = '1;
            endcase
        else
            need = LEN_W'($urandom_range(63));
        return {need, code};
    endfunction

    function automatic void gen_random_line();
        int                cand[$];
        int                pick;
        int                sel;
        int                need;
        int                n;
        logic [CODE_W-1:0] code;
        for (int i = 0; i < NUM_ENTRIES; i++)
        begin
            code = cmd_table[i][CODE_W-1:0];
            need = cmd_table[i][ENTRY_W-1:CODE_W];
            if (code == TABLE_END)
                break;
            if (need >= 1 && need < BUF_DEPTH && code != CH_NEWLINE && code != CH_RETURN)
                cand.push_back(i);
        end
        pick = $urandom_range(99);
        if (cand.size() != 0 && pick < 80)
        begin
            sel = cand[$urandom_range(cand.size() - 1)];
            code = cmd_table[sel][CODE_W-1:0];
            need = cmd_table[sel][ENTRY_W-1:CODE_W];
            if (pick < 70)
                push_line(code, need);
            else if ($urandom_range(1) == 0)
                push_line(body_byte(), need);
            else
            begin
                n = ($urandom_range(1) == 0 && need < BUF_DEPTH - 1) ? need + 1 : need - 1;
                push_line(code, (n == 0) ? need + 1 : n);
            end
        end
        else if (pick < 88)
        begin
            n = $urandom_range(6);
            for (int k = 0; k < n; k++)
                push_byte(body_byte() | (($urandom_range(3) == 0) ? CH_RETURN : '0));
            push_byte(CH_NEWLINE);
        end
        else if (pick < 94)
        begin
            n = ($urandom_range(3) == 0) ? $urandom_range(2 * BUF_DEPTH, 2 * BUF_DEPTH + 6)
                                         : $urandom_range(BUF_DEPTH, BUF_DEPTH + 8);
            for (int k = 0; k < n; k++)
                push_byte(body_byte());
            push_byte(CH_NEWLINE);
        end
        else
        begin
            n = $urandom_range(1, 5);
            for (int k = 0; k < n; k++)
                push_byte(BYTE_W'($urandom_range(255)));
        end
    endfunction

    initial
    begin
        entry_t prev;
        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // directed table: all-ones entry, code-only entry with zero length, duplicate pair
        staged_table[0] = {6'd1, 8'hFF};
        staged_table[1] = {6'd2, 8'h01};
        staged_table[2] = '1;
        staged_table[3] = {6'd0, 8'h42};
        staged_table[4] = {6'd3, 8'h41};
        staged_table[5] = {6'd3, 8'h41};
        load_table(1'b1, '1);

        push_line(8'hFF, 1);
        push_byte(8'h01);
        push_byte(8'h00);
        push_byte(CH_NEWLINE);
        push_byte(8'h41);
        push_byte(CH_RETURN);
        push_byte(8'h80);
        push_byte(8'h7F);
        push_byte(CH_NEWLINE);
        push_byte(CH_NEWLINE);
        push_line(8'h5A, 1);
        push_byte(8'h41);
        push_byte(8'h42);
        push_byte(CH_NEWLINE);
        push_line(8'h42, 1);
        push_byte(CH_RETURN);
        push_byte(CH_NEWLINE);

        for (int ph = 0; ph < NUM_PHASES; ph++)
        begin
            wait_drained();
            case (ph / 2)
                0:
                begin
                    send_idle_pct = 33;
                    recv_idle_pct = 48;
                end
                1:
                begin
                    send_idle_pct = 48;
                    recv_idle_pct = 33;
                end
                default:
                begin
                    send_idle_pct = 0;
                    recv_idle_pct = 0;
                end
            endcase
            prev = ENTRY_W'($urandom_range(255));
            for (int i = 0; i < NUM_ENTRIES; i++)
            begin
                staged_table[i] = (ph == 3) ? entry_t'(0) : make_entry(prev);
                if (i == 0 && staged_table[i][CODE_W-1:0] == TABLE_END && ph != 3)
                    staged_table[i][CODE_W-1:0] = CODE_W'($urandom_range(1, 255));
                prev = staged_table[i];
            end
            if (ph == NUM_PHASES - 1)
                staged_table[0] = '0;
            load_table($urandom_range(1) == 1, ENTRY_W'($urandom_range(16383)));
            queued_items = 0;
            while (queued_items < ITEMS_PER_PHASE)
                gen_random_line();
        end

        wait_drained();
        $display("run covered %0d bytes and %0d results: %0d matched lines, %0d unknown",
                 bytes_taken, results_seen, matched_lines, unknown_lines);
        $display("%0d command tables loaded, %0d writes to unused register indexes",
                 tables_loaded, spare_writes);
        if (errors == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

    initial
    begin
        #(TIMEOUT);
        $display("timeout with %0d results still outstanding", expected_results.size());
        $display("[FAIL] regression broken");
        $finish;
    end

endmodule
